// ----- hw/rtl/crp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types, constants and saturation helpers of the MHD
// conserved-to-primitive pipeline.
// ----------------------------------------------------------------------------
package crp_pkg;

   // number formats
   localparam int unsigned DATA_W = 32;
   localparam int unsigned CFG_W  = 31;

   // passive scalars the datapath can carry
   localparam logic [1:0] MAX_SCALARS = 2'd2;

   // divider geometry: 64 bit dividend, 31 bit divisor, 32 quotient bits
   localparam int unsigned DIV_NUM_W = 64;
   localparam int unsigned DIV_Q_W   = 32;
   localparam int unsigned DIV_D_W   = 31;

   // divider lanes: three velocities, two scalars, kinetic energy
   localparam int unsigned RATIO_LANES = 5;
   localparam int unsigned DIV_LANES   = 6;
   localparam int unsigned LANE_SCALAR = 3;
   localparam int unsigned LANE_EK     = 5;

   // register reset values
   localparam logic [CFG_W-1:0] GM1_RESET  = 31'd43691;
   localparam logic [CFG_W-1:0] IGM1_RESET = 31'd98304;

   // saturation limits
   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;
   localparam logic signed [63:0] S64_HI  = 64'sh000000007fffffff;
   localparam logic signed [63:0] S64_LO  = -64'sh0000000080000000;
   localparam logic [30:0]        U31_MAX = 31'h7fffffff;

   typedef enum logic [2:0] {
      CSR_GAMMA_M1     = 3'd0,
      CSR_INV_GAMMA_M1 = 3'd1,
      CSR_DENS_FLOOR   = 3'd2,
      CSR_PRES_FLOOR   = 3'd3,
      CSR_EINT_FLOOR   = 3'd4,
      CSR_SCALAR_COUNT = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_PRES_FLOOR   = 3'd1,
      ST_EINT_FLOOR   = 3'd2,
      ST_BAD_DENSITY  = 3'd3,
      ST_BAD_PRESSURE = 3'd4
   } status_type;

   typedef struct packed {
      logic [CFG_W-1:0] gamma_minus_one;
      logic [CFG_W-1:0] inverse_gamma_minus_one;
      logic [CFG_W-1:0] density_floor;
      logic [CFG_W-1:0] pressure_floor;
      logic [CFG_W-1:0] internal_energy_floor;
      logic [1:0]       scalar_count;
   } crp_cfg_type;

   typedef struct packed {
      logic signed [31:0] density;
      logic signed [31:0] momentum_x;
      logic signed [31:0] momentum_y;
      logic signed [31:0] momentum_z;
      logic signed [31:0] total_energy;
      logic signed [31:0] field_x;
      logic signed [31:0] field_y;
      logic signed [31:0] field_z;
      logic signed [31:0] scalar_a;
      logic signed [31:0] scalar_b;
   } crp_req_type;

   typedef struct packed {
      logic signed [31:0] density_out;
      logic signed [31:0] velocity_x;
      logic signed [31:0] velocity_y;
      logic signed [31:0] velocity_z;
      logic signed [31:0] pressure;
      logic signed [31:0] energy_out;
      logic signed [31:0] scalar_a_ratio;
      logic signed [31:0] scalar_b_ratio;
      logic [2:0]         status;
   } crp_rsp_type;

   // cell data that rides alongside the divider
   typedef struct packed {
      logic                   bad_density;
      logic [CFG_W-1:0]       d;
      logic signed [31:0]     energy;
      logic [CFG_W-1:0]       eb;
      logic [RATIO_LANES-1:0] neg;
      logic [1:0]             use_scalar;
   } crp_side_type;

   // clamp an unsigned value to 31 bits
   function automatic logic [30:0] sat_u31(input logic [63:0] x);
      return (x > 64'h000000007fffffff) ? U31_MAX : x[30:0];
   endfunction

   // clamp a signed value to 32 bits
   function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > S64_HI) begin
         r = S32_MAX;
      end else if (x < S64_LO) begin
         r = S32_MIN;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crp_if
// Request, response and register write channels of the pipeline.
// ----------------------------------------------------------------------------
interface crp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] density;
   logic signed [31:0] momentum_x;
   logic signed [31:0] momentum_y;
   logic signed [31:0] momentum_z;
   logic signed [31:0] total_energy;
   logic signed [31:0] field_x;
   logic signed [31:0] field_y;
   logic signed [31:0] field_z;
   logic signed [31:0] scalar_a;
   logic signed [31:0] scalar_b;

   modport source (output valid, density, momentum_x, momentum_y, momentum_z,
                   total_energy, field_x, field_y, field_z, scalar_a, scalar_b,
                   input ready);
   modport sink (input valid, density, momentum_x, momentum_y, momentum_z,
                 total_energy, field_x, field_y, field_z, scalar_a, scalar_b,
                 output ready);
endinterface

interface crp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] density_out;
   logic signed [31:0] velocity_x;
   logic signed [31:0] velocity_y;
   logic signed [31:0] velocity_z;
   logic signed [31:0] pressure;
   logic signed [31:0] energy_out;
   logic signed [31:0] scalar_a_ratio;
   logic signed [31:0] scalar_b_ratio;
   logic [2:0]         status;

   modport source (output valid, density_out, velocity_x, velocity_y, velocity_z,
                   pressure, energy_out, scalar_a_ratio, scalar_b_ratio, status,
                   input ready);
   modport sink (input valid, density_out, velocity_x, velocity_y, velocity_z,
                 pressure, energy_out, scalar_a_ratio, scalar_b_ratio, status,
                 output ready);
endinterface

interface crp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/crp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crp_front
// Input register, density floor, squares and divider operand setup
// (three pipeline stages).
// ----------------------------------------------------------------------------
module crp_front
   import crp_pkg::*;
(
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire crp_req_type                          in_data,
   input  wire crp_cfg_type                          cfg,
   output logic                                      out_valid,
   output crp_side_type                              out_side,
   output logic [DIV_LANES-1:0][DIV_NUM_W-1:0]       out_dividend,
   output logic [DIV_D_W-1:0]                        out_divisor
);

   // stage 1: request register
   logic        s1_valid_ff;
   crp_req_type s1_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_data_ff <= in_data;
      end
   end

   // stage 2: density floor, squares, magnitudes
   logic                   s2_valid_ff;
   logic                   s2_bad_ff,    s2_bad_in;
   logic [CFG_W-1:0]       s2_d_ff,      s2_d_in;
   logic signed [31:0]     s2_e_ff;
   logic [62:0]            s2_sqm_ff [3];
   logic [62:0]            s2_sqm_in [3];
   logic [62:0]            s2_sqb_ff [3];
   logic [62:0]            s2_sqb_in [3];
   logic [31:0]            s2_mag_ff [RATIO_LANES];
   logic [31:0]            s2_mag_in [RATIO_LANES];
   logic [RATIO_LANES-1:0] s2_neg_ff,    s2_neg_in;
   logic [1:0]             s2_use_ff,    s2_use_in;

   always_comb begin
      logic signed [31:0] dfl;
      logic signed [31:0] num [RATIO_LANES];
      logic signed [31:0] fld [3];
      logic signed [63:0] sq;
      logic [1:0]         nsc;
      dfl = $signed({1'b0, cfg.density_floor});
      num[0] = s1_data_ff.momentum_x;
      num[1] = s1_data_ff.momentum_y;
      num[2] = s1_data_ff.momentum_z;
      num[3] = s1_data_ff.scalar_a;
      num[4] = s1_data_ff.scalar_b;
      fld[0] = s1_data_ff.field_x;
      fld[1] = s1_data_ff.field_y;
      fld[2] = s1_data_ff.field_z;

      // clamp density; a non-positive one with no floor is fatal
      s2_bad_in = (s1_data_ff.density <= 32'sd0) && (cfg.density_floor == '0);
      if (s1_data_ff.density > dfl) begin
         s2_d_in = s1_data_ff.density[CFG_W-1:0];
      end else begin
         s2_d_in = cfg.density_floor;
      end

      for (int k = 0; k < 3; k++) begin
         sq = num[k] * num[k];
         s2_sqm_in[k] = sq[62:0];
         sq = fld[k] * fld[k];
         s2_sqb_in[k] = sq[62:0];
      end

      for (int k = 0; k < RATIO_LANES; k++) begin
         s2_neg_in[k] = num[k][31];
         s2_mag_in[k] = num[k][31] ? (32'd0 - num[k]) : num[k];
      end

      // scalars in use
      nsc = (cfg.scalar_count > MAX_SCALARS) ? MAX_SCALARS : cfg.scalar_count;
      s2_use_in[0] = (nsc >= 2'd1);
      s2_use_in[1] = (nsc >= 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_bad_ff <= s2_bad_in;
         s2_d_ff   <= s2_d_in;
         s2_e_ff   <= s1_data_ff.total_energy;
         s2_sqm_ff <= s2_sqm_in;
         s2_sqb_ff <= s2_sqb_in;
         s2_mag_ff <= s2_mag_in;
         s2_neg_ff <= s2_neg_in;
         s2_use_ff <= s2_use_in;
      end
   end

   // stage 3: sums, magnetic energy, dividends
   logic                               s3_valid_ff;
   crp_side_type                       s3_side_ff,  s3_side_in;
   logic [DIV_LANES-1:0][DIV_NUM_W-1:0] s3_div_ff,   s3_div_in;

   always_comb begin
      logic [63:0] sum_m;
      logic [63:0] sum_b;
      sum_m = {1'b0, s2_sqm_ff[0]} + {1'b0, s2_sqm_ff[1]} + {1'b0, s2_sqm_ff[2]};
      sum_b = {1'b0, s2_sqb_ff[0]} + {1'b0, s2_sqb_ff[1]} + {1'b0, s2_sqb_ff[2]};

      s3_side_in.bad_density = s2_bad_ff;
      s3_side_in.d           = s2_d_ff;
      s3_side_in.energy      = s2_e_ff;
      s3_side_in.eb          = sat_u31(sum_b >> 17);
      s3_side_in.neg         = s2_neg_ff;
      s3_side_in.use_scalar  = s2_use_ff;

      // ratio lanes divide value * 2^16, kinetic lane divides sum / 2
      for (int k = 0; k < RATIO_LANES; k++) begin
         s3_div_in[k] = {16'd0, s2_mag_ff[k], 16'd0};
      end
      s3_div_in[LANE_EK] = {1'b0, sum_m[63:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_side_ff <= s3_side_in;
         s3_div_ff  <= s3_div_in;
      end
   end

   assign out_valid    = s3_valid_ff;
   assign out_side     = s3_side_ff;
   assign out_dividend = s3_div_ff;
   assign out_divisor  = s3_side_ff.d;

endmodule
`default_nettype wire

// ----- hw/rtl/crp_div_bank.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crp_div_bank
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Flags quotients that do not fit 32 bits.
// ----------------------------------------------------------------------------
module crp_div_bank
   import crp_pkg::*;
#(
   parameter int unsigned LANES = DIV_LANES
)
(
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic [LANES-1:0][DIV_NUM_W-1:0]  dividend,
   input  wire logic [DIV_D_W-1:0]               divisor,
   output logic      [LANES-1:0][DIV_Q_W-1:0]    quotient,
   output logic      [LANES-1:0]                 overflow
);

   localparam int unsigned HI_W = DIV_NUM_W - DIV_Q_W;

   // chain index i is the input of stage i
   logic [LANES-1:0][DIV_D_W-1:0] rem_chain [DIV_Q_W+1];
   logic [LANES-1:0][DIV_Q_W-1:0] low_chain [DIV_Q_W+1];
   logic [LANES-1:0][DIV_Q_W-1:0] quo_chain [DIV_Q_W+1];
   logic [LANES-1:0]              ovf_chain [DIV_Q_W+1];
   logic [DIV_D_W-1:0]            dvs_chain [DIV_Q_W+1];

   // entry: upper half is the starting remainder, too large means overflow
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rem_chain[0][l] = dividend[l][DIV_NUM_W-2 -: DIV_D_W];
         low_chain[0][l] = dividend[l][DIV_Q_W-1:0];
         quo_chain[0][l] = '0;
         ovf_chain[0][l] = dividend[l][DIV_NUM_W-1 -: HI_W] >=
                           {{(HI_W-DIV_D_W){1'b0}}, divisor};
      end
      dvs_chain[0] = divisor;
   end

   for (genvar i = 0; i < DIV_Q_W; i++) begin : g_step
      logic [LANES-1:0][DIV_D_W-1:0] rem_ff, rem_in;
      logic [LANES-1:0][DIV_Q_W-1:0] low_ff, low_in;
      logic [LANES-1:0][DIV_Q_W-1:0] quo_ff, quo_in;
      logic [LANES-1:0]              ovf_ff;
      logic [DIV_D_W-1:0]            dvs_ff;

      // trial subtract of one shifted-in bit
      always_comb begin
         logic [DIV_D_W:0] trial;
         logic [DIV_D_W:0] diff;
         logic             ge;
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_chain[i][l], low_chain[i][l][DIV_Q_W-1]};
            diff  = trial - {1'b0, dvs_chain[i]};
            ge    = trial >= {1'b0, dvs_chain[i]};
            rem_in[l] = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            low_in[l] = {low_chain[i][l][DIV_Q_W-2:0], 1'b0};
            quo_in[l] = {quo_chain[i][l][DIV_Q_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            low_ff <= low_in;
            quo_ff <= quo_in;
            ovf_ff <= ovf_chain[i];
            dvs_ff <= dvs_chain[i];
         end
      end

      assign rem_chain[i+1] = rem_ff;
      assign low_chain[i+1] = low_ff;
      assign quo_chain[i+1] = quo_ff;
      assign ovf_chain[i+1] = ovf_ff;
      assign dvs_chain[i+1] = dvs_ff;
   end

   assign quotient = quo_chain[DIV_Q_W];
   assign overflow = ovf_chain[DIV_Q_W];

endmodule
`default_nettype wire

// ----- hw/rtl/crp_delay.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crp_delay
// Shift line that carries valid and cell data alongside the divider.
// ----------------------------------------------------------------------------
module crp_delay #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   output logic      [WIDTH-1:0] out_data
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // data taps
   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule
`default_nettype wire

// ----- hw/rtl/crp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crp_back
// Quotient saturation, pressure, floors and the response register
// (four pipeline stages).
// ----------------------------------------------------------------------------
module crp_back
   import crp_pkg::*;
(
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire crp_cfg_type                        cfg,
   input  wire logic                               in_valid,
   input  wire crp_side_type                       in_side,
   input  wire logic [DIV_LANES-1:0][DIV_Q_W-1:0]  in_quotient,
   input  wire logic [DIV_LANES-1:0]               in_overflow,
   output logic                                    out_valid,
   output crp_rsp_type                             out_data
);

   // pressure floor energy, from registers only
   logic [CFG_W-1:0] pe_ff;

   always_ff @(posedge clock) begin
      logic [61:0] prod;
      prod  = cfg.pressure_floor * cfg.inverse_gamma_minus_one;
      pe_ff <= sat_u31({2'b0, prod} >> 16);
   end

   // stage p1: signed ratios, kinetic energy, E - ek - eb, d * floor
   logic               p1_valid_ff;
   logic               p1_bad_ff;
   logic signed [31:0] p1_e_ff;
   logic [CFG_W-1:0]   p1_ek_ff,  p1_ek_in;
   logic [CFG_W-1:0]   p1_eb_ff;
   logic signed [31:0] p1_rat_ff [RATIO_LANES];
   logic signed [31:0] p1_rat_in [RATIO_LANES];
   logic signed [31:0] p1_t_ff,   p1_t_in;
   logic [61:0]        p1_dep_ff, p1_dep_in;

   always_comb begin
      logic signed [33:0] diff;
      for (int k = 0; k < RATIO_LANES; k++) begin
         if (!in_side.neg[k]) begin
            p1_rat_in[k] = (in_overflow[k] || in_quotient[k][31]) ? S32_MAX
                           : $signed(in_quotient[k]);
         end else begin
            p1_rat_in[k] = (in_overflow[k] || (in_quotient[k] > 32'h80000000))
                           ? S32_MIN : $signed(32'd0 - in_quotient[k]);
         end
      end
      // unused scalars read as zero
      for (int k = 0; k < 2; k++) begin
         if (!in_side.use_scalar[k]) begin
            p1_rat_in[LANE_SCALAR + k] = '0;
         end
      end

      p1_ek_in = (in_overflow[LANE_EK] || in_quotient[LANE_EK][31]) ? U31_MAX
                 : in_quotient[LANE_EK][30:0];

      diff = {{2{in_side.energy[31]}}, in_side.energy}
             - $signed({3'b0, p1_ek_in}) - $signed({3'b0, in_side.eb});
      p1_t_in = sat_s32({{30{diff[33]}}, diff});

      p1_dep_in = in_side.d * cfg.internal_energy_floor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_bad_ff <= in_side.bad_density;
         p1_e_ff   <= in_side.energy;
         p1_ek_ff  <= p1_ek_in;
         p1_eb_ff  <= in_side.eb;
         p1_rat_ff <= p1_rat_in;
         p1_t_ff   <= p1_t_in;
         p1_dep_ff <= p1_dep_in;
      end
   end

   // keep the floored density beside the ratios
   logic [CFG_W-1:0] p1_d_ff, p2_d_ff, p3_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_d_ff <= in_side.d;
         p2_d_ff <= p1_d_ff;
         p3_d_ff <= p2_d_ff;
      end
   end

   // stage p2: gas pressure product, floor energy and its pressure product
   logic               p2_valid_ff;
   logic               p2_bad_ff;
   logic signed [31:0] p2_e_ff;
   logic signed [31:0] p2_rat_ff [RATIO_LANES];
   logic signed [63:0] p2_pp_ff,  p2_pp_in;
   logic [CFG_W-1:0]   p2_de_ff,  p2_de_in;
   logic [61:0]        p2_efp_ff, p2_efp_in;
   logic [31:0]        p2_keb_ff, p2_keb_in;

   always_comb begin
      p2_pp_in  = $signed({1'b0, cfg.gamma_minus_one}) * p1_t_ff;
      p2_de_in  = sat_u31({2'b0, p1_dep_ff} >> 16);
      p2_efp_in = cfg.gamma_minus_one * p2_de_in;
      p2_keb_in = {1'b0, p1_ek_ff} + {1'b0, p1_eb_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_bad_ff <= p1_bad_ff;
         p2_e_ff   <= p1_e_ff;
         p2_rat_ff <= p1_rat_ff;
         p2_pp_ff  <= p2_pp_in;
         p2_de_ff  <= p2_de_in;
         p2_efp_ff <= p2_efp_in;
         p2_keb_ff <= p2_keb_in;
      end
   end

   // stage p3: scale pressure, effective floor, corrected energies
   logic               p3_valid_ff;
   logic               p3_bad_ff;
   logic signed [31:0] p3_e_ff;
   logic signed [31:0] p3_rat_ff [RATIO_LANES];
   logic signed [31:0] p3_p_ff,   p3_p_in;
   logic [CFG_W-1:0]   p3_eff_ff, p3_eff_in;
   logic [CFG_W-1:0]   p3_epf_ff, p3_epf_in;
   logic [CFG_W-1:0]   p3_ede_ff, p3_ede_in;

   always_comb begin
      p3_p_in   = sat_s32(p2_pp_ff >>> 16);
      p3_eff_in = sat_u31({2'b0, p2_efp_ff} >> 16);
      p3_epf_in = sat_u31({33'd0, pe_ff} + {32'd0, p2_keb_ff});
      p3_ede_in = sat_u31({33'd0, p2_de_ff} + {32'd0, p2_keb_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_bad_ff <= p2_bad_ff;
         p3_e_ff   <= p2_e_ff;
         p3_rat_ff <= p2_rat_ff;
         p3_p_ff   <= p3_p_in;
         p3_eff_ff <= p3_eff_in;
         p3_epf_ff <= p3_epf_in;
         p3_ede_ff <= p3_ede_in;
      end
   end

   // stage p4: apply the floors in order, error codes, response register
   logic        out_valid_ff;
   crp_rsp_type out_data_ff, out_data_in;

   always_comb begin
      logic signed [31:0] pf;
      logic signed [31:0] eff;
      logic signed [31:0] p_sel;
      logic signed [31:0] e_sel;
      logic               bad_p;
      status_type         st;
      pf    = $signed({1'b0, cfg.pressure_floor});
      eff   = $signed({1'b0, p3_eff_ff});
      p_sel = p3_p_ff;
      e_sel = p3_e_ff;
      st    = ST_OK;

      if ((cfg.pressure_floor != '0) && (p3_p_ff < pf)) begin
         p_sel = pf;
         e_sel = $signed({1'b0, p3_epf_ff});
         st    = ST_PRES_FLOOR;
      end
      if (p_sel < eff) begin
         p_sel = eff;
         e_sel = $signed({1'b0, p3_ede_ff});
         st    = ST_EINT_FLOOR;
      end

      bad_p = (p3_p_ff <= 32'sd0) && (cfg.pressure_floor == '0)
              && (cfg.internal_energy_floor == '0);

      out_data_in = '0;
      priority if (p3_bad_ff) begin
         out_data_in.status = ST_BAD_DENSITY;
      end else if (bad_p) begin
         out_data_in.status = ST_BAD_PRESSURE;
      end else begin
         out_data_in.density_out    = $signed({1'b0, p3_d_ff});
         out_data_in.velocity_x     = p3_rat_ff[0];
         out_data_in.velocity_y     = p3_rat_ff[1];
         out_data_in.velocity_z     = p3_rat_ff[2];
         out_data_in.pressure       = p_sel;
         out_data_in.energy_out     = e_sel;
         out_data_in.scalar_a_ratio = p3_rat_ff[LANE_SCALAR];
         out_data_in.scalar_b_ratio = p3_rat_ff[LANE_SCALAR + 1];
         out_data_in.status         = st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/mhd_conserved_to_primitive_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhd_conserved_to_primitive_core
// Ideal-gas MHD conserved-to-primitive conversion, one cell per cycle while not stalled.
// ----------------------------------------------------------------------------
// The block accepts one cell per clock while the response side keeps up and
// returns one response per cell, in order, through three front stages
// (input register, density floor and squares, sums and operand setup),
// a 32-stage divider bank that produces one quotient bit per stage for all
// six divisions of the cell at once, and four back stages (saturation,
// pressure product, floor energies, floor selection and response register).
// The divider depth sets the latency. The whole pipeline advances whenever
// the response register is empty or being taken, so a stall on the response
// side holds every stage in place. Registers are to be written only while no
// request is in flight, which the block itself does not enforce; the write port is always ready.
// ----------------------------------------------------------------------------
module mhd_conserved_to_primitive_core
   import crp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   crp_req_if.sink    req_if,
   crp_rsp_if.source  rsp_if,
   crp_csr_if.sink    csr_if
);

   // configuration registers
   crp_cfg_type cfg_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gamma_minus_one         <= GM1_RESET;
         cfg_ff.inverse_gamma_minus_one <= IGM1_RESET;
         cfg_ff.density_floor           <= '0;
         cfg_ff.pressure_floor          <= '0;
         cfg_ff.internal_energy_floor   <= '0;
         cfg_ff.scalar_count            <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_GAMMA_M1:     cfg_ff.gamma_minus_one         <= csr_if.data[CFG_W-1:0];
            CSR_INV_GAMMA_M1: cfg_ff.inverse_gamma_minus_one <= csr_if.data[CFG_W-1:0];
            CSR_DENS_FLOOR:   cfg_ff.density_floor           <= csr_if.data[CFG_W-1:0];
            CSR_PRES_FLOOR:   cfg_ff.pressure_floor          <= csr_if.data[CFG_W-1:0];
            CSR_EINT_FLOOR:   cfg_ff.internal_energy_floor   <= csr_if.data[CFG_W-1:0];
            CSR_SCALAR_COUNT: cfg_ff.scalar_count            <= csr_if.data[1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance
   logic out_valid;
   logic en;

   assign en           = !out_valid || rsp_if.ready;
   assign req_if.ready = en;

   // request payload
   crp_req_type req_data;

   always_comb begin
      req_data.density      = req_if.density;
      req_data.momentum_x   = req_if.momentum_x;
      req_data.momentum_y   = req_if.momentum_y;
      req_data.momentum_z   = req_if.momentum_z;
      req_data.total_energy = req_if.total_energy;
      req_data.field_x      = req_if.field_x;
      req_data.field_y      = req_if.field_y;
      req_data.field_z      = req_if.field_z;
      req_data.scalar_a     = req_if.scalar_a;
      req_data.scalar_b     = req_if.scalar_b;
   end

   // front stages
   logic                                front_valid;
   crp_side_type                        front_side;
   logic [DIV_LANES-1:0][DIV_NUM_W-1:0] front_dividend;
   logic [DIV_D_W-1:0]                  front_divisor;

   crp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_if.valid),
      .in_data      (req_data),
      .cfg          (cfg_ff),
      .out_valid    (front_valid),
      .out_side     (front_side),
      .out_dividend (front_dividend),
      .out_divisor  (front_divisor)
   );

   // divider bank
   logic [DIV_LANES-1:0][DIV_Q_W-1:0] div_quotient;
   logic [DIV_LANES-1:0]              div_overflow;

   crp_div_bank #(
      .LANES (DIV_LANES)
   ) u_div_bank (
      .clock    (clock),
      .en       (en),
      .dividend (front_dividend),
      .divisor  (front_divisor),
      .quotient (div_quotient),
      .overflow (div_overflow)
   );

   // cell data alongside the divider
   logic         side_valid;
   crp_side_type side_data;

   crp_delay #(
      .WIDTH ($bits(crp_side_type)),
      .DEPTH (DIV_Q_W)
   ) u_delay (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_side),
      .out_valid (side_valid),
      .out_data  (side_data)
   );

   // back stages
   crp_rsp_type rsp_data;

   crp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .cfg         (cfg_ff),
      .in_valid    (side_valid),
      .in_side     (side_data),
      .in_quotient (div_quotient),
      .in_overflow (div_overflow),
      .out_valid   (out_valid),
      .out_data    (rsp_data)
   );

   // response channel
   assign rsp_if.valid          = out_valid;
   assign rsp_if.density_out    = rsp_data.density_out;
   assign rsp_if.velocity_x     = rsp_data.velocity_x;
   assign rsp_if.velocity_y     = rsp_data.velocity_y;
   assign rsp_if.velocity_z     = rsp_data.velocity_z;
   assign rsp_if.pressure       = rsp_data.pressure;
   assign rsp_if.energy_out     = rsp_data.energy_out;
   assign rsp_if.scalar_a_ratio = rsp_data.scalar_a_ratio;
   assign rsp_if.scalar_b_ratio = rsp_data.scalar_b_ratio;
   assign rsp_if.status         = rsp_data.status;

endmodule
`default_nettype wire

// ----- test/crp_cell_checker.sv -----
// ----------------------------------------------------------------------------
// crp_cell_checker
// Watches the request, response and register channels of the MHD
// conserved-to-primitive core. It keeps its own copy of the registers,
// predicts the primitive state of every accepted request and compares
// each response, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module crp_cell_checker
   import crp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   crp_req_if     req,
   crp_rsp_if     rsp,
   crp_csr_if     csr,
   output int     errors,
   output int     pending
);

   crp_cfg_type cfg;
   crp_rsp_type primitive_q[$];

   // clamp to the signed 32 bit range
   function automatic longint clamp_s32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // clamp an unsigned value to the positive 32 bit range
   function automatic longint clamp_u32(input longint unsigned v);
      if (v > 64'd2147483647) return 64'sd2147483647;
      return longint'(v);
   endfunction

   // Q15.16 quotient, truncated toward zero
   function automatic longint per_density(input longint num, input longint d);
      return clamp_s32((num * 65536) / d);
   endfunction

   // primitive state of one cell under the given registers
   function automatic crp_rsp_type convert_cell(input crp_cfg_type c, input crp_req_type q);
      crp_rsp_type r;
      longint rho, d, df, mx, my, mz, bx, by, bz, e, ek, eb, p, pf, ief, gm1, igm1;
      longint de, eff, pe;
      longint unsigned ssum;
      int nsc;
      r = '0;
      r.status = ST_OK;
      rho = q.density;
      df = c.density_floor;
      pf = c.pressure_floor;
      ief = c.internal_energy_floor;
      gm1 = c.gamma_minus_one;
      igm1 = c.inverse_gamma_minus_one;
      if (rho <= 0 && df == 0) begin
         r.status = ST_BAD_DENSITY;
         return r;
      end
      d = (rho > df) ? rho : df;
      mx = q.momentum_x;
      my = q.momentum_y;
      mz = q.momentum_z;
      bx = q.field_x;
      by = q.field_y;
      bz = q.field_z;
      e = q.total_energy;
      // kinetic and magnetic energy
      ssum = longint'(mx * mx) + longint'(my * my) + longint'(mz * mz);
      ek = clamp_u32(ssum / longint'(2 * d));
      ssum = longint'(bx * bx) + longint'(by * by) + longint'(bz * bz);
      eb = clamp_u32(ssum >> 17);
      p = clamp_s32((gm1 * clamp_s32(e - ek - eb)) >>> 16);
      if (!(p > 0 || pf > 0 || ief > 0)) begin
         r.status = ST_BAD_PRESSURE;
         return r;
      end
      // pressure floor, then internal energy floor
      if (pf > 0 && p < pf) begin
         pe = clamp_s32((pf * igm1) >>> 16);
         e = clamp_s32(pe + ek + eb);
         p = pf;
         r.status = ST_PRES_FLOOR;
      end
      de = clamp_s32((d * ief) >>> 16);
      eff = clamp_s32((gm1 * de) >>> 16);
      if (p < eff) begin
         e = clamp_s32(de + ek + eb);
         p = eff;
         r.status = ST_EINT_FLOOR;
      end
      nsc = (c.scalar_count > MAX_SCALARS) ? MAX_SCALARS : c.scalar_count;
      r.density_out = d[31:0];
      r.velocity_x = 32'(per_density(mx, d));
      r.velocity_y = 32'(per_density(my, d));
      r.velocity_z = 32'(per_density(mz, d));
      r.pressure = p[31:0];
      r.energy_out = e[31:0];
      r.scalar_a_ratio = (nsc > 0) ? 32'(per_density(longint'(q.scalar_a), d)) : 32'd0;
      r.scalar_b_ratio = (nsc > 1) ? 32'(per_density(longint'(q.scalar_b), d)) : 32'd0;
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // track registers, predict, compare
   always @(posedge clock) begin
      crp_rsp_type want;
      crp_req_type item;
      if (reset) begin
         cfg <= '{gamma_minus_one: GM1_RESET, inverse_gamma_minus_one: IGM1_RESET,
                  density_floor: '0, pressure_floor: '0, internal_energy_floor: '0,
                  scalar_count: '0};
         primitive_q.delete();
         pending <= 0;
      end else begin
         // responses first: a request taken now cannot be answered now
         if (rsp.valid && rsp.ready) begin
            if (primitive_q.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = primitive_q.pop_front();
               check_field("density_out", want.density_out, rsp.density_out);
               check_field("velocity_x", want.velocity_x, rsp.velocity_x);
               check_field("velocity_y", want.velocity_y, rsp.velocity_y);
               check_field("velocity_z", want.velocity_z, rsp.velocity_z);
               check_field("pressure", want.pressure, rsp.pressure);
               check_field("energy_out", want.energy_out, rsp.energy_out);
               check_field("scalar_a_ratio", want.scalar_a_ratio, rsp.scalar_a_ratio);
               check_field("scalar_b_ratio", want.scalar_b_ratio, rsp.scalar_b_ratio);
               check_field("status", want.status, rsp.status);
            end
         end
         if (req.valid && req.ready) begin
            item.density = req.density;
            item.momentum_x = req.momentum_x;
            item.momentum_y = req.momentum_y;
            item.momentum_z = req.momentum_z;
            item.total_energy = req.total_energy;
            item.field_x = req.field_x;
            item.field_y = req.field_y;
            item.field_z = req.field_z;
            item.scalar_a = req.scalar_a;
            item.scalar_b = req.scalar_b;
            primitive_q.push_back(convert_cell(cfg, item));
         end
         pending <= primitive_q.size();
         // register writes, indexes past the list are ignored
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_GAMMA_M1:     cfg.gamma_minus_one <= csr.data[30:0];
               CSR_INV_GAMMA_M1: cfg.inverse_gamma_minus_one <= csr.data[30:0];
               CSR_DENS_FLOOR:   cfg.density_floor <= csr.data[30:0];
               CSR_PRES_FLOOR:   cfg.pressure_floor <= csr.data[30:0];
               CSR_EINT_FLOOR:   cfg.internal_energy_floor <= csr.data[30:0];
               CSR_SCALAR_COUNT: cfg.scalar_count <= csr.data[1:0];
               default: ;
            endcase
         end
      end
   end

   initial errors = 0;

endmodule

// ----- test/mhd_conserved_to_primitive_core_test.sv -----
// ----------------------------------------------------------------------------
// mhd_conserved_to_primitive_core_test
// Drives cells and register settings into the conserved-to-primitive core
// under random idling and one long response stall; a separate checker
// predicts and compares every response. Directed cells cover field
// extremes, bad density, bad pressure and both floors; random cells are
// mostly physical states with some raw noise.
// ----------------------------------------------------------------------------
module mhd_conserved_to_primitive_core_test;
   import crp_pkg::*;

   localparam logic [2:0] CSR_PAST_END = 3'd6;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 45;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int errors, pending;
   int idle_max = 5;
   bit hold_rsp = 1'b0;
   int cells_sent = 0;
   int idle_count = 0;

   crp_req_if req_ch();
   crp_rsp_if rsp_ch();
   crp_csr_if csr_ch();

   always #5 clock = ~clock;

   mhd_conserved_to_primitive_core uut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch), .csr_if(csr_ch)
   );

   crp_cell_checker cell_check (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .errors(errors), .pending(pending)
   );

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // response side: random hold-offs, one long stall on request
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            n = $urandom_range(0, idle_max);
            if (n > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   function automatic crp_req_type mk_cell(
      input logic [31:0] d, mx, my, mz, e, bx, by, bz, sa, sb);
      crp_req_type c;
      c = '{d, mx, my, mz, e, bx, by, bz, sa, sb};
      return c;
   endfunction

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 7))
         0: return S32_MIN;
         1: return S32_MAX;
         2: return 32'd0;
         3: return 32'hffffffff;
         4: return 32'd1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] around(input int unsigned k);
      return $urandom_range(0, 2 * k) - k;
   endfunction

   // mostly physical cells, some raw noise
   function automatic crp_req_type random_cell();
      if ($urandom_range(0, 3) == 0)
         return mk_cell(any_word(), any_word(), any_word(), any_word(), any_word(),
                        any_word(), any_word(), any_word(), any_word(), any_word());
      return mk_cell($urandom_range(1 << 10, 1 << 21), around(1 << 20), around(1 << 20),
                     around(1 << 20), $urandom_range(0, 1 << 24) - (1 << 18),
                     around(1 << 18), around(1 << 18), around(1 << 18),
                     around(1 << 22), around(1 << 22));
   endfunction

   task automatic send_cell(input crp_req_type c);
      int n;
      n = $urandom_range(0, idle_max);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.density <= c.density;
      req_ch.momentum_x <= c.momentum_x;
      req_ch.momentum_y <= c.momentum_y;
      req_ch.momentum_z <= c.momentum_z;
      req_ch.total_energy <= c.total_energy;
      req_ch.field_x <= c.field_x;
      req_ch.field_y <= c.field_y;
      req_ch.field_z <= c.field_z;
      req_ch.scalar_a <= c.scalar_a;
      req_ch.scalar_b <= c.scalar_b;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      cells_sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
   endtask

   // all registers plus one write past the list, with the block idle
   task automatic set_config(input logic [31:0] gm1, igm1, dfl, pfl, efl, nsc);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_GAMMA_M1, gm1);
      write_reg(CSR_INV_GAMMA_M1, igm1);
      write_reg(CSR_DENS_FLOOR, dfl);
      write_reg(CSR_PRES_FLOOR, pfl);
      write_reg(CSR_EINT_FLOOR, efl);
      write_reg(CSR_SCALAR_COUNT, nsc);
      write_reg(CSR_PAST_END, $urandom());
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_cells(input int count);
      for (int i = 0; i < count; i++) begin
         // stretches without idling
         if (i % 60 == 0) idle_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
         send_cell(random_cell());
      end
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.density <= '0;
      req_ch.momentum_x <= '0;
      req_ch.momentum_y <= '0;
      req_ch.momentum_z <= '0;
      req_ch.total_energy <= '0;
      req_ch.field_x <= '0;
      req_ch.field_y <= '0;
      req_ch.field_z <= '0;
      req_ch.scalar_a <= '0;
      req_ch.scalar_b <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset register values, nothing written yet
      random_cells(40);

      // directed cells with two scalars in use
      set_config(43691, 98304, 0, 0, 0, 2);
      send_cell(mk_cell(32'h10000, 32'h8000, -32'sh8000, 32'h4000, 32'h40000,
                        32'h1000, 32'h2000, -32'sh1000, 32'h20000, -32'sh30000));
      send_cell(mk_cell(0, 1, 2, 3, 32'h10000, 0, 0, 0, 5, 6));              // zero density
      send_cell(mk_cell(S32_MIN, 1, 2, 3, 32'h10000, 0, 0, 0, 5, 6));        // negative density
      send_cell(mk_cell(1, S32_MAX, S32_MIN, S32_MAX, S32_MAX,
                        0, 0, 0, S32_MAX, S32_MIN));                         // saturating ratios
      send_cell(mk_cell(S32_MAX, S32_MIN, S32_MIN, S32_MIN, S32_MAX,
                        S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MAX));
      send_cell(mk_cell(S32_MAX, 0, 0, 0, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1, 1));
      send_cell(mk_cell(32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 0));              // zero pressure
      send_cell(mk_cell(32'h10000, 32'h10000, 0, 0, S32_MIN, 0, 0, 0, 0, 0)); // negative pressure
      send_cell(mk_cell(32'h10000, 0, 0, 0, 32'h1, 0, 0, 0, 0, 0));
      send_cell(mk_cell(32'hffffffff, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      send_cell(mk_cell(32'h7, -32'sh7, 32'h7, -32'sh1, S32_MAX, 32'hffff, 32'h1ffff,
                        32'h3, -32'sh7, 32'h7));
      random_cells(160);

      // light floors, one scalar; the long response stall happens here
      set_config(26214, 163840, 655, 6554, 0, 1);
      hold_rsp = 1'b1;
      random_cells(180);

      // density and energy floors, scalar count past the maximum
      set_config(43691, 98304, 6554, 0, 3277, 3);
      send_cell(mk_cell(S32_MIN, 32'h100, 0, 0, 32'h10000, 0, 0, 0, 32'h100, 32'h200));
      send_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      random_cells(180);

      // both floors active, directed cells where both apply
      set_config(43691, 98304, 65536, 13107, 6554, 2);
      send_cell(mk_cell(32'h10000, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 32'h8000));
      send_cell(mk_cell(32'h40000, 32'h1000, 0, 0, 32'h100, 0, 0, 0, 0, 0));
      send_cell(mk_cell(S32_MIN, 0, 0, 0, S32_MIN, 0, 0, 0, 0, 0));
      random_cells(180);

      // register maxima
      set_config(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 2);
      random_cells(150);

      // register minima
      set_config(1, 1, 0, 1, 1, 0);
      random_cells(150);

      // back to a plain gas with floors
      set_config(43691, 98304, 655, 655, 655, 2);
      random_cells(150);

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d cells over eight register settings, extremes included,", cells_sent);
      $display("with random idling on both channels and one long response stall");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
